@@ rtl/core/crlu_pkg.sv @@
// ----------------------------------------------------------------------------
// crlu_pkg
// Shared types and constants for the Crout LU linear solver.
// ----------------------------------------------------------------------------
package crlu_pkg;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_LK_INIT,
        ST_LK_RD,
        ST_LK_MAC,
        ST_LK_WR,
        ST_PIV,
        ST_UK_INIT,
        ST_UK_RD,
        ST_UK_MAC,
        ST_UK_DIV,
        ST_UK_WR,
        ST_FZ_INIT,
        ST_FZ_RD,
        ST_FZ_MAC,
        ST_FZ_DIV,
        ST_FZ_WR,
        ST_BX_INIT,
        ST_BX_RD,
        ST_BX_MAC,
        ST_BX_WR,
        ST_OUT_RD,
        ST_OUT
    } crlu_state_t;

    typedef struct packed {
        logic                start;
        logic signed [63:0]  num;
        logic signed [31:0]  den;
    } crlu_div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic signed [31:0]  quo;
    } crlu_div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) r = 32'sh7fffffff;
        else if (v < S32_MIN) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/crlu_divider.sv @@
// ----------------------------------------------------------------------------
// crlu_divider
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module crlu_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crlu_pkg::crlu_div_req_t req,
    output crlu_pkg::crlu_div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [64:0] trial;
    logic [63:0] rem_sh;
    logic signed [64:0] sres;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[62:0], quo_reg[63]};
        trial     = {1'b0, rem_sh} - {33'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            quo_next  = req.num[63] ? 64'(-req.num) : 64'(req.num);
            rem_next  = '0;
            den_next  = req.den[31] ? 32'(-req.den) : 32'(req.den);
            neg_next  = req.num[63] ^ req.den[31];
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign sres = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (sres > 65'sd2147483647) rsp.quo = 32'sh7fffffff;
        else if (sres < -65'sd2147483648) rsp.quo = 32'sh80000000;
        else rsp.quo = sres[31:0];
    end

endmodule

@@ rtl/core/crout_lu_linear_solver_unit.sv @@
// ----------------------------------------------------------------------------
// crout_lu_linear_solver_unit
// Loads an N x N system plus right-hand side, solves it by Crout LU
// decomposition with forward and back substitution, emits N solutions.
// ----------------------------------------------------------------------------
// Flow: load values are accepted only in the load state (in_stall low); the
//   solve takes roughly N^3/3 memory read-multiply-accumulate steps plus
//   N(N+1)/2 divisions in the bit-serial divider.
// Each result is read from vector memory, then registered; out_stall holds it.
// Reset: control clears, size_reg becomes 8; memories are not cleared.
module crout_lu_linear_solver_unit
#(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] solution,
    output logic [2:0]         index,
    output logic               singular,
    output logic               last
);

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = 2 * IW;
    localparam int CW = IW + 1;

    // matrix memory holds A, then L (lower incl. diag) and U (upper) in place
    logic signed [31:0] mat_mem [MAX_N*MAX_N];
    // vector memory holds b, then z, then x in place
    logic signed [31:0] vec_mem [MAX_N];

    crlu_pkg::crlu_state_t state_reg, state_next;

    logic [3:0]  size_reg;
    logic [6:0]  ld_cnt_reg, ld_cnt_next;
    logic [CW-1:0] ld_row_reg, ld_row_next, ld_col_reg, ld_col_next;
    logic [CW-1:0] n_eff;
    logic        sing_reg, sing_next;
    logic [CW-1:0] k_reg, k_next, i_reg, i_next, p_reg, p_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] opa_reg, opa_next;
    logic signed [31:0] piv_reg, piv_next;
    logic        mph_reg, mph_next;

    logic        m_we, v_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [IW-1:0] v_waddr, v_raddr;
    logic signed [31:0] m_wdata, v_wdata, m_rdata_reg, v_rdata_reg;

    logic signed [63:0] prod_reg;
    logic        prod_vld_reg;
    logic signed [63:0] prod_sh;

    crlu_pkg::crlu_div_req_t dreq;
    crlu_pkg::crlu_div_rsp_t drsp;

    logic              ov_reg, ov_next;
    logic signed [31:0] os_reg, os_next;
    logic [2:0]        oi_reg, oi_next;
    logic              osg_reg, osg_next;
    logic              ol_reg, ol_next;
    logic              accept, mul_go;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] diff;

    assign n_eff = (size_reg == 4'd0) ? CW'(1) :
                   ((32'(size_reg) > MAX_N) ? CW'(MAX_N) : CW'(size_reg));

    function automatic logic [AW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return {r[IW-1:0], c[IW-1:0]};
    endfunction

    always_ff @(posedge clk)
    begin
        if (m_we) mat_mem[m_waddr] <= m_wdata;
        m_rdata_reg <= mat_mem[m_raddr];
        if (v_we) vec_mem[v_waddr] <= v_wdata;
        v_rdata_reg <= vec_mem[v_raddr];
    end

    crlu_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // multiply stage: operand a from opa_reg or memory data, operand b from memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) prod_vld_reg <= 1'b0;
        else prod_vld_reg <= mul_go;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    assign prod_sh = 64'(crlu_pkg::sat32(prod_reg >>> FRAC_BITS));
    assign diff = crlu_pkg::sat32(64'(opa_reg) - acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= crlu_pkg::ST_LOAD;
            size_reg   <= 4'd8;
            ld_cnt_reg <= '0;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
            sing_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            k_reg      <= '0;
            i_reg      <= '0;
            p_reg      <= '0;
            mph_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we) size_reg <= cfg_wdata;
            ld_cnt_reg <= ld_cnt_next;
            ld_row_reg <= ld_row_next;
            ld_col_reg <= ld_col_next;
            sing_reg   <= sing_next;
            ov_reg     <= ov_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            p_reg      <= p_next;
            mph_reg    <= mph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        piv_reg <= piv_next;
        os_reg  <= os_next;
        oi_reg  <= oi_next;
        osg_reg <= osg_next;
        ol_reg  <= ol_next;
    end

    assign in_stall  = (state_reg != crlu_pkg::ST_LOAD);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign solution  = os_reg;
    assign index     = oi_reg;
    assign singular  = osg_reg;
    assign last      = ol_reg;

    always_comb
    begin
        state_next  = state_reg;
        ld_cnt_next = ld_cnt_reg;
        ld_row_next = ld_row_reg;
        ld_col_next = ld_col_reg;
        sing_next   = sing_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        acc_next    = acc_reg;
        opa_next    = opa_reg;
        piv_next    = piv_reg;
        mph_next    = mph_reg;
        ov_next     = ov_reg && out_stall;
        os_next     = os_reg;
        oi_next     = oi_reg;
        osg_next    = osg_reg;
        ol_next     = ol_reg;
        m_we        = 1'b0;
        v_we        = 1'b0;
        m_waddr     = maddr(ld_row_reg, ld_col_reg);
        m_raddr     = '0;
        v_waddr     = ld_row_reg[IW-1:0];
        v_raddr     = '0;
        m_wdata     = value;
        v_wdata     = value;
        mul_go      = 1'b0;
        mul_a       = opa_reg;
        mul_b       = m_rdata_reg;
        dreq.start  = 1'b0;
        dreq.num    = 64'(diff) <<< FRAC_BITS;
        dreq.den    = piv_reg;

        case (state_reg)
            crlu_pkg::ST_LOAD:
            begin
                if (cfg_we)
                begin
                    ld_cnt_next = '0;
                    ld_row_next = '0;
                    ld_col_next = '0;
                end
                else if (accept)
                begin
                    if (ld_row_reg < n_eff)
                    begin
                        if (ld_col_reg < n_eff) m_we = 1'b1;
                        else v_we = 1'b1;
                    end
                    ld_cnt_next = ld_cnt_reg + 7'd1;
                    if (ld_col_reg == n_eff)
                    begin
                        ld_col_next = '0;
                        ld_row_next = ld_row_reg + CW'(1);
                    end
                    else ld_col_next = ld_col_reg + CW'(1);
                    if (ld_cnt_next >= 7'(32'(n_eff) * (32'(n_eff) + 1)))
                    begin
                        ld_cnt_next = '0;
                        ld_row_next = '0;
                        ld_col_next = '0;
                        sing_next   = 1'b0;
                        k_next      = '0;
                        i_next      = '0;
                        state_next  = crlu_pkg::ST_LK_INIT;
                    end
                end
            end
            // L[i][k] = A[i][k] - sum_p L[i][p]*U[p][k]
            crlu_pkg::ST_LK_INIT:
            begin
                acc_next   = '0;
                p_next     = '0;
                mph_next   = 1'b0;
                state_next = crlu_pkg::ST_LK_RD;
            end
            crlu_pkg::ST_LK_RD:
            begin
                if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                if (p_reg < k_reg)
                begin
                    m_raddr    = maddr(i_reg, p_reg);
                    state_next = crlu_pkg::ST_LK_MAC;
                end
                else
                begin
                    m_raddr    = maddr(i_reg, k_reg);
                    state_next = crlu_pkg::ST_LK_WR;
                    mph_next   = 1'b0;
                end
            end
            crlu_pkg::ST_LK_MAC:
            begin
                if (!mph_reg)
                begin
                    opa_next = m_rdata_reg;
                    m_raddr  = maddr(p_reg, k_reg);
                    mph_next = 1'b1;
                end
                else
                begin
                    mul_go     = 1'b1;
                    mph_next   = 1'b0;
                    p_next     = p_reg + CW'(1);
                    state_next = crlu_pkg::ST_LK_RD;
                end
            end
            crlu_pkg::ST_LK_WR:
            begin
                if (!mph_reg)
                begin
                    if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                    opa_next = m_rdata_reg;
                    mph_next = 1'b1;
                end
                else
                begin
                    mph_next = 1'b0;
                    m_we     = 1'b1;
                    m_waddr  = maddr(i_reg, k_reg);
                    m_wdata  = diff;
                    if (i_reg == k_reg) piv_next = diff;
                    if (i_reg + CW'(1) < n_eff)
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = crlu_pkg::ST_LK_INIT;
                    end
                    else state_next = crlu_pkg::ST_PIV;
                end
            end
            crlu_pkg::ST_PIV:
            begin
                if (piv_reg == 32'sd0)
                begin
                    sing_next  = 1'b1;
                    i_next     = '0;
                    state_next = crlu_pkg::ST_OUT_RD;
                end
                else
                begin
                    i_next     = k_reg + CW'(1);
                    state_next = (k_reg + CW'(1) < n_eff) ? crlu_pkg::ST_UK_INIT
                                                          : crlu_pkg::ST_FZ_INIT;
                    if (k_reg + CW'(1) >= n_eff) i_next = '0;
                end
            end
            // U[k][j] = (A[k][j] - sum_p L[k][p]*U[p][j]) / L[k][k], j in i_reg
            crlu_pkg::ST_UK_INIT:
            begin
                acc_next   = '0;
                p_next     = '0;
                mph_next   = 1'b0;
                state_next = crlu_pkg::ST_UK_RD;
            end
            crlu_pkg::ST_UK_RD:
            begin
                if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                if (p_reg < k_reg)
                begin
                    m_raddr    = maddr(k_reg, p_reg);
                    state_next = crlu_pkg::ST_UK_MAC;
                end
                else
                begin
                    m_raddr    = maddr(k_reg, i_reg);
                    state_next = crlu_pkg::ST_UK_DIV;
                end
            end
            crlu_pkg::ST_UK_MAC:
            begin
                if (!mph_reg)
                begin
                    opa_next = m_rdata_reg;
                    m_raddr  = maddr(p_reg, i_reg);
                    mph_next = 1'b1;
                end
                else
                begin
                    mul_go     = 1'b1;
                    mph_next   = 1'b0;
                    p_next     = p_reg + CW'(1);
                    state_next = crlu_pkg::ST_UK_RD;
                end
            end
            crlu_pkg::ST_UK_DIV:
            begin
                if (!mph_reg)
                begin
                    if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                    opa_next = m_rdata_reg;
                    mph_next = 1'b1;
                end
                else
                begin
                    mph_next   = 1'b0;
                    dreq.start = 1'b1;
                    state_next = crlu_pkg::ST_UK_WR;
                end
            end
            crlu_pkg::ST_UK_WR:
            begin
                if (drsp.done)
                begin
                    m_we    = 1'b1;
                    m_waddr = maddr(k_reg, i_reg);
                    m_wdata = drsp.quo;
                    if (i_reg + CW'(1) < n_eff)
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = crlu_pkg::ST_UK_INIT;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        i_next     = k_reg + CW'(1);
                        state_next = crlu_pkg::ST_LK_INIT;
                    end
                end
            end
            // z[i] = (b[i] - sum_p L[i][p]*z[p]) / L[i][i]
            crlu_pkg::ST_FZ_INIT:
            begin
                acc_next   = '0;
                p_next     = '0;
                mph_next   = 1'b0;
                state_next = crlu_pkg::ST_FZ_RD;
            end
            crlu_pkg::ST_FZ_RD:
            begin
                if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                if (p_reg < i_reg)
                begin
                    m_raddr    = maddr(i_reg, p_reg);
                    v_raddr    = p_reg[IW-1:0];
                    state_next = crlu_pkg::ST_FZ_MAC;
                end
                else
                begin
                    m_raddr    = maddr(i_reg, i_reg);
                    v_raddr    = i_reg[IW-1:0];
                    state_next = crlu_pkg::ST_FZ_DIV;
                end
            end
            crlu_pkg::ST_FZ_MAC:
            begin
                mul_a      = m_rdata_reg;
                mul_b      = v_rdata_reg;
                state_next = crlu_pkg::ST_FZ_RD;
                p_next     = p_reg + CW'(1);
                mph_next   = 1'b1;
            end
            crlu_pkg::ST_FZ_DIV:
            begin
                if (!mph_reg)
                begin
                    if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                    opa_next = v_rdata_reg;
                    piv_next = m_rdata_reg;
                    mph_next = 1'b1;
                end
                else
                begin
                    mph_next   = 1'b0;
                    dreq.start = 1'b1;
                    state_next = crlu_pkg::ST_FZ_WR;
                end
            end
            crlu_pkg::ST_FZ_WR:
            begin
                if (drsp.done)
                begin
                    v_we    = 1'b1;
                    v_waddr = i_reg[IW-1:0];
                    v_wdata = drsp.quo;
                    if (i_reg + CW'(1) < n_eff)
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = crlu_pkg::ST_FZ_INIT;
                    end
                    else state_next = crlu_pkg::ST_BX_INIT;
                end
            end
            // x[i] = z[i] - sum_{p>i} U[i][p]*x[p], i descending
            crlu_pkg::ST_BX_INIT:
            begin
                acc_next   = '0;
                p_next     = i_reg + CW'(1);
                mph_next   = 1'b0;
                state_next = crlu_pkg::ST_BX_RD;
            end
            crlu_pkg::ST_BX_RD:
            begin
                if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                if (p_reg < n_eff)
                begin
                    m_raddr    = maddr(i_reg, p_reg);
                    v_raddr    = p_reg[IW-1:0];
                    state_next = crlu_pkg::ST_BX_MAC;
                end
                else
                begin
                    v_raddr    = i_reg[IW-1:0];
                    state_next = crlu_pkg::ST_BX_WR;
                end
            end
            crlu_pkg::ST_BX_MAC:
            begin
                mul_a      = m_rdata_reg;
                mul_b      = v_rdata_reg;
                p_next     = p_reg + CW'(1);
                state_next = crlu_pkg::ST_BX_RD;
            end
            crlu_pkg::ST_BX_WR:
            begin
                if (!mph_reg)
                begin
                    if (prod_vld_reg) acc_next = acc_reg + prod_sh;
                    opa_next = v_rdata_reg;
                    mph_next = 1'b1;
                end
                else
                begin
                    mph_next = 1'b0;
                    v_we     = 1'b1;
                    v_waddr  = i_reg[IW-1:0];
                    v_wdata  = diff;
                    if (i_reg == '0)
                    begin
                        state_next = crlu_pkg::ST_OUT_RD;
                    end
                    else
                    begin
                        i_next     = i_reg - CW'(1);
                        state_next = crlu_pkg::ST_BX_INIT;
                    end
                end
            end
            crlu_pkg::ST_OUT_RD:
            begin
                v_raddr    = i_reg[IW-1:0];
                state_next = crlu_pkg::ST_OUT;
            end
            crlu_pkg::ST_OUT:
            begin
                v_raddr = i_reg[IW-1:0];
                if (!ov_reg || !out_stall)
                begin
                    ov_next  = 1'b1;
                    os_next  = sing_reg ? 32'sd0 : v_rdata_reg;
                    oi_next  = 3'(i_reg);
                    osg_next = sing_reg;
                    ol_next  = (i_reg + CW'(1) == n_eff);
                    if (i_reg + CW'(1) == n_eff)
                    begin
                        i_next     = '0;
                        state_next = crlu_pkg::ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = crlu_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = crlu_pkg::ST_LOAD;
            end
        endcase

        // back substitution starts from the last index
        if (state_reg == crlu_pkg::ST_FZ_WR && drsp.done && !(i_reg + CW'(1) < n_eff))
            i_next = n_eff - CW'(1);
        if (state_reg == crlu_pkg::ST_FZ_MAC) mph_next = 1'b0;
        if (state_reg == crlu_pkg::ST_FZ_MAC || state_reg == crlu_pkg::ST_BX_MAC)
            mul_go = 1'b1;
    end

endmodule

@@ rtl/core/crlu_checker.sv @@
// ----------------------------------------------------------------------------
// crlu_checker
// Port-level checks on the solver's handshake and result stream.
// ----------------------------------------------------------------------------
module crlu_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] solution,
    input logic [2:0]         index,
    input logic               singular,
    input logic               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(solution) && $stable(index))
        else $error("stalled result changed");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> solution == 32'sd0)
        else $error("singular result not zero");

    a_no_load_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input open mid result stream");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last ##1 out_valid |-> index != $past(index))
        else $error("index repeated");

endmodule

bind crout_lu_linear_solver_unit crlu_checker u_crlu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .solution  (solution),
    .index     (index),
    .singular  (singular),
    .last      (last)
);

@@ sim/tb_crout_lu_linear_solver_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crout_lu_linear_solver_unit
// Loads random and directed linear systems at several sizes, predicts the
// Crout LU solution in fixed point and checks every emitted solution value.
// ----------------------------------------------------------------------------
module tb_crout_lu_linear_solver_unit;

    localparam int MAXN = 8;
    localparam int FB   = 16;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] solution;
        logic [2:0]         index;
        logic               singular;
        logic               last;
    } sol_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] solution;
    logic [2:0]         index;
    logic               singular;
    logic               last;

    crout_lu_linear_solver_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .solution(solution),
        .index(index), .singular(singular), .last(last)
    );

    longint  coef_mem [MAXN*MAXN];
    longint  rhs_mem [MAXN];
    int      loaded;
    int      size_reg;
    sol_t    pending_solutions[$];
    int      errors;
    longint  cycles;
    bit      quiet_in;
    bit      quiet_out;
    int      hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint sat(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return sat(p >>> FB);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        return sat((num * (64'sd1 <<< FB)) / den);
    endfunction

    function automatic int active_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAXN) return MAXN;
        return size_reg;
    endfunction

    task automatic solve_system();
        longint lm[MAXN][MAXN];
        longint um[MAXN][MAXN];
        longint z[MAXN];
        longint x[MAXN];
        longint acc;
        bit     zero_piv;
        int     n;
        sol_t   r;
        n = active_size();
        zero_piv = 0;
        for (int a = 0; a < MAXN; a++)
        begin
            z[a] = 0;
            x[a] = 0;
            for (int b = 0; b < MAXN; b++)
            begin
                lm[a][b] = 0;
                um[a][b] = 0;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            um[k][k] = 64'sd1 <<< FB;
            for (int i = k; i < n; i++)
            begin
                acc = 0;
                for (int p = 0; p < k; p++) acc += fx_mul(lm[i][p], um[p][k]);
                lm[i][k] = sat(coef_mem[i*MAXN+k] - acc);
            end
            if (lm[k][k] == 0)
            begin
                zero_piv = 1;
                break;
            end
            for (int j = k + 1; j < n; j++)
            begin
                acc = 0;
                for (int p = 0; p < k; p++) acc += fx_mul(lm[k][p], um[p][j]);
                um[k][j] = fx_div(sat(coef_mem[k*MAXN+j] - acc), lm[k][k]);
            end
        end
        if (!zero_piv)
        begin
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int p = 0; p < i; p++) acc += fx_mul(lm[i][p], z[p]);
                z[i] = fx_div(sat(rhs_mem[i] - acc), lm[i][i]);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                acc = 0;
                for (int p = i + 1; p < n; p++) acc += fx_mul(um[i][p], x[p]);
                x[i] = sat(z[i] - acc);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.solution = zero_piv ? 32'sd0 : x[i][31:0];
            r.index    = i[2:0];
            r.singular = zero_piv;
            r.last     = (i == n - 1);
            pending_solutions.push_back(r);
        end
    endtask

    task automatic load_entry(longint v);
        int n;
        int row;
        int col;
        n = active_size();
        row = loaded / (n + 1);
        col = loaded % (n + 1);
        if (row < n)
        begin
            if (col < n) coef_mem[row*MAXN+col] = v;
            else rhs_mem[row] = v;
        end
        loaded = (loaded + 1) & 8'h7f;
        if (loaded >= n * (n + 1))
        begin
            loaded = 0;
            solve_system();
        end
    endtask

    task automatic send_value(logic signed [31:0] v);
        while (!quiet_in && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        load_entry(longint'(v));
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        sol_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_solutions.size() == 0)
                report_mismatch("unexpected transfer", solution, 0);
            else
            begin
                w = pending_solutions.pop_front();
                if (solution !== w.solution) report_mismatch("solution", solution, w.solution);
                if (index !== w.index) report_mismatch("index", index, w.index);
                if (singular !== w.singular) report_mismatch("singular", singular, w.singular);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet_out && ($urandom_range(99) < 14);
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic set_size(int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[3:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        size_reg = n;
        loaded = 0;
    endtask

    function automatic logic signed [31:0] rand_small();
        return $signed($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
    endfunction

    task automatic send_system(bit diag_dom);
        int n;
        n = active_size();
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
                if (diag_dom && c == r)
                    send_value(32'sh0010_0000 + rand_small());
                else if (diag_dom)
                    send_value(rand_small());
                else
                    send_value($urandom());
    endtask

    task automatic test_extremes();
        set_size(2);
        send_value(32'sh7fffffff); send_value(32'sh80000000); send_value(32'sh7fffffff);
        send_value(32'sh80000000); send_value(32'sh00000001); send_value(32'sh80000000);
        set_size(1);
        send_value(32'sh00010000); send_value(32'sh7fffffff);
        send_value(32'sh00000001); send_value(32'sh80000000);
        set_size(0);
        send_value(32'shffffffff); send_value(32'sh00030000);
    endtask

    task automatic test_singular();
        set_size(2);
        send_value(0); send_value(32'sh10000); send_value(32'sh10000);
        send_value(32'sh10000); send_value(0); send_value(32'sh20000);
        send_value(32'sh10000); send_value(32'sh20000); send_value(32'sh10000);
        send_value(32'sh20000); send_value(32'sh40000); send_value(32'sh30000);
    endtask

    task automatic test_partial_drop();
        set_size(3);
        repeat (5) send_value(rand_small());
        set_size(15);
        send_system(1);
    endtask

    task automatic test_backpressure();
        set_size(2);
        send_system(1);
        hold_off = 400;
        repeat (3) send_system(1);
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 240)
        begin
            n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
            set_size(n);
            quiet_in  = (sent > 120 && sent < 180);
            quiet_out = quiet_in;
            repeat ($urandom_range(1, 3))
            begin
                send_system($urandom_range(9) != 0);
                sent += n * (n + 1);
            end
        end
        quiet_in  = 0;
        quiet_out = 0;
    endtask

    initial
    begin
        errors    = 0;
        cycles    = 0;
        loaded    = 0;
        size_reg  = 8;
        hold_off  = 0;
        quiet_in  = 0;
        quiet_out = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 4'd0;
        in_valid  = 1'b0;
        value     = 32'sd0;
        out_stall = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_singular();
        test_partial_drop();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/crlu_pkg.sv
rtl/core/crlu_divider.sv
rtl/core/crout_lu_linear_solver_unit.sv
rtl/core/crlu_checker.sv
sim/tb_crout_lu_linear_solver_unit.sv
